// ===== rtl/acpd_pkg.sv =====
// Package for the autocorrelation period detector.
// Holds fixed field widths, register indexes, reset values and Q2.14 limits.
// No dependencies; every rtl file imports it.
package acpd_pkg;

    // Correlation accumulator width; it wraps like a 64-bit integer.
    localparam int ACC_W     = 64;
    // Q2.14 fraction bits and quotient bits of the normalizing divide.
    localparam int FRAC_BITS = 14;
    localparam int Q_BITS    = 17;
    // Result and register field widths.
    localparam int STR_W     = 16;
    localparam int PER_W     = 10;
    // Configuration bus widths.
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // Register indexes (word address bits [3:2]).
    localparam logic [1:0] REG_LAG_LO = 2'd0;
    localparam logic [1:0] REG_LAG_HI = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    // Register reset values.
    localparam logic [PER_W-1:0]        RST_LAG_LO = 10'd2;
    localparam logic [PER_W-1:0]        RST_LAG_HI = 10'd1023;
    localparam logic signed [STR_W-1:0] RST_THRESH = 16'sd8192;

    // Saturation limits of the strength value.
    localparam logic signed [STR_W-1:0] STR_MAX   = 16'sh7fff;
    localparam logic signed [STR_W-1:0] STR_MIN   = 16'sh8000;
    localparam logic [Q_BITS-1:0]       Q_POS_LIM = 17'd32767;
    localparam logic [Q_BITS-1:0]       Q_NEG_LIM = 17'd32768;

endpackage

// ===== rtl/acpd_norm.sv =====
// Normalizer: strength = C(k) * n * 2^14 / ((n - k) * C(0)), truncated, saturated.
// Shift-add multiplies followed by a restoring divide, one quotient bit a cycle.
// Depends on acpd_pkg.
module acpd_norm #(
    parameter int CNT_W = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [acpd_pkg::ACC_W-1:0]       acc,
    input  logic [acpd_pkg::ACC_W-1:0]       c0,
    input  logic [CNT_W-1:0]                 n_cnt,
    input  logic [CNT_W-1:0]                 span,
    output logic                             done,
    output logic signed [acpd_pkg::STR_W-1:0] ratio
);
    import acpd_pkg::*;

    localparam int WW     = ACC_W + CNT_W + Q_BITS;
    localparam int STEP_N = (CNT_W > Q_BITS) ? CNT_W : Q_BITS;
    localparam int STEP_W = $clog2(STEP_N + 1);

    typedef enum logic [1:0] {N_IDLE, N_MUL, N_DIV, N_OUT} norm_state_t;

    norm_state_t               state_reg;
    logic                      neg_reg;
    logic [WW-1:0]             num_mc_reg;
    logic [WW-1:0]             den_mc_reg;
    logic [WW-1:0]             num_reg;
    logic [WW-1:0]             den_reg;
    logic [CNT_W-1:0]          mn_reg;
    logic [CNT_W-1:0]          md_reg;
    logic [STEP_W-1:0]         cnt_reg;
    logic [Q_BITS-1:0]         q_reg;
    logic                      done_reg;
    logic signed [STR_W-1:0]   ratio_reg;

    logic [ACC_W-1:0]          mag;
    logic [WW-1:0]             num_sum;
    logic [WW-1:0]             den_sum;
    logic                      ge;
    logic signed [STR_W-1:0]   sat_val;

    // Magnitude of the correlation sum.
    assign mag = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;

    // One partial product of each multiply per cycle.
    assign num_sum = num_reg + (mn_reg[0] ? num_mc_reg : WW'(0));
    assign den_sum = den_reg + (md_reg[0] ? den_mc_reg : WW'(0));

    // Restoring divide step.
    assign ge = (num_reg >= den_reg);

    // Truncated quotient, saturated to Q2.14 with the sign applied.
    always_comb
    begin
        if (neg_reg)
        begin
            sat_val = (q_reg > Q_NEG_LIM) ? STR_MIN : -$signed(q_reg[STR_W-1:0]);
        end
        else
        begin
            sat_val = (q_reg > Q_POS_LIM) ? STR_MAX : $signed(q_reg[STR_W-1:0]);
        end
    end

    // Sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg    <= acc[ACC_W-1];
                        num_mc_reg <= WW'(mag);
                        den_mc_reg <= WW'(c0);
                        num_reg    <= '0;
                        den_reg    <= '0;
                        mn_reg     <= n_cnt;
                        md_reg     <= span;
                        cnt_reg    <= '0;
                        state_reg  <= N_MUL;
                    end
                end
                N_MUL:
                begin
                    num_mc_reg <= num_mc_reg << 1;
                    den_mc_reg <= den_mc_reg << 1;
                    mn_reg     <= mn_reg >> 1;
                    md_reg     <= md_reg >> 1;
                    if (cnt_reg == STEP_W'(CNT_W - 1))
                    begin
                        num_reg   <= num_sum << FRAC_BITS;
                        den_reg   <= den_sum << (Q_BITS - 1);
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= N_DIV;
                    end
                    else
                    begin
                        num_reg <= num_sum;
                        den_reg <= den_sum;
                        cnt_reg <= cnt_reg + STEP_W'(1);
                    end
                end
                N_DIV:
                begin
                    if (ge)
                    begin
                        num_reg <= num_reg - den_reg;
                    end
                    q_reg   <= {q_reg[Q_BITS-2:0], ge};
                    den_reg <= den_reg >> 1;
                    if (cnt_reg == STEP_W'(Q_BITS - 1))
                    begin
                        state_reg <= N_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + STEP_W'(1);
                    end
                end
                N_OUT:
                begin
                    ratio_reg <= sat_val;
                    done_reg  <= 1'b1;
                    state_reg <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign ratio = ratio_reg;

endmodule

// ===== rtl/autocorrelation_period_detector.sv =====
// Top level of the autocorrelation period detector: sample memory, lag loop,
// correlation pipeline, peak search, result register and APB registers.
// Depends on acpd_pkg and acpd_norm.
//
//   Channel   Direction  Handshake               Beat
//   input     in         in_valid / in_stall     sample, last
//   output    out        out_valid / out_stall   found, period, strength
//   config    in/out     APB psel/penable/pready lag_lo, lag_hi, threshold
//
// A beat with last starts the search: lag k reads its n - k products through the
// sample memory's two read ports and is then normalized when C(0) is not zero; the
// scan stops at the first peak, at the upper search lag or at the end of the window.
// Reset clears the count, the sum, the flags and the sequencer and loads the reset values.
// in_stall is high from the last beat until the result is loaded; a result
// waiting on out_stall does not block loading samples of the next window.
module autocorrelation_period_detector #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [acpd_pkg::PER_W-1:0]         period,
    output logic signed [acpd_pkg::STR_W-1:0]  strength,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [acpd_pkg::PADDR_W-1:0]       paddr,
    input  logic [acpd_pkg::PDATA_W-1:0]       pwdata,
    output logic [acpd_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import acpd_pkg::*;

    localparam int AW     = $clog2(MAX_SAMPLES);
    localparam int CW     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_BITS + CW;
    localparam int NX_W   = SAMPLE_BITS + CW + 1;
    localparam int DEV_W  = NX_W + 1;
    localparam int PROD_W = 2 * DEV_W;
    localparam int CMP_W  = (CW > PER_W) ? CW : PER_W;

    typedef enum logic [2:0] {S_IDLE, S_ACC, S_DRAIN, S_NORM, S_EVAL, S_DONE} state_t;

    // Configuration registers.
    logic [PER_W-1:0]          lag_lo_reg;
    logic [PER_W-1:0]          lag_hi_reg;
    logic signed [STR_W-1:0]   thresh_reg;
    logic                      cfg_wr;

    // Window and sequencer state.
    state_t                    state_reg;
    logic [CW-1:0]             count_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CW-1:0]             win_n_reg;
    logic signed [SUM_W-1:0]   win_sum_reg;
    logic [CW-1:0]             lag_reg;
    logic [AW-1:0]             i_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [ACC_W-1:0]          c0_reg;
    logic signed [STR_W-1:0]   r_new_reg;
    logic signed [STR_W-1:0]   r_prev_reg;
    logic signed [STR_W-1:0]   r_cur_reg;
    logic                      hit_reg;
    logic [PER_W-1:0]          hit_lag_reg;
    logic signed [STR_W-1:0]   hit_val_reg;
    logic                      out_valid_reg;
    logic                      found_reg;
    logic [PER_W-1:0]          period_reg;
    logic signed [STR_W-1:0]   strength_reg;

    // Sample memory and correlation pipeline.
    logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
    logic signed [SAMPLE_BITS-1:0] rd_a_reg;
    logic signed [SAMPLE_BITS-1:0] rd_b_reg;
    logic signed [NX_W-1:0]        nx_a_reg;
    logic signed [NX_W-1:0]        nx_b_reg;
    logic signed [DEV_W-1:0]       dev_a_reg;
    logic signed [DEV_W-1:0]       dev_b_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          p1_reg;
    logic                          p2_reg;
    logic                          p3_reg;
    logic                          p4_reg;

    logic                      in_acc;
    logic                      wr_en;
    logic [CW-1:0]             n_close;
    logic signed [SUM_W-1:0]   sum_close;
    logic                      rd_en;
    logic [CW-1:0]             span;
    logic [AW-1:0]             last_i;
    logic [CW-1:0]             lagged;
    logic                      drained;
    logic [ACC_W-1:0]          c0_eff;
    logic                      norm_start;
    logic                      norm_done;
    logic signed [STR_W-1:0]   norm_ratio;
    logic                      tail;
    logic [CW-1:0]             cand;
    logic signed [STR_W-1:0]   r_next_v;
    logic signed [STR_W-1:0]   r_prev_v;
    logic                      qualify;
    logic                      at_max;
    logic                      out_load;

    // APB register file; writes land on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_lo_reg <= RST_LAG_LO;
            lag_hi_reg <= RST_LAG_HI;
            thresh_reg <= RST_THRESH;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_LAG_LO: lag_lo_reg <= pwdata[PER_W-1:0];
                REG_LAG_HI: lag_hi_reg <= pwdata[PER_W-1:0];
                REG_THRESH: thresh_reg <= $signed(pwdata[STR_W-1:0]);
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LAG_LO: prdata = PDATA_W'(lag_lo_reg);
            REG_LAG_HI: prdata = PDATA_W'(lag_hi_reg);
            REG_THRESH: prdata = PDATA_W'($unsigned(thresh_reg));
            default:    prdata = '0;
        endcase
    end

    // Sample load: samples past the memory depth are dropped.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign wr_en     = in_acc && (count_reg < CW'(MAX_SAMPLES));
    assign n_close   = count_reg + CW'(wr_en);
    assign sum_close = sum_reg + (wr_en ? SUM_W'(sample) : SUM_W'(0));

    // Read addresses for the product d[i] * d[i + k].
    assign rd_en  = (state_reg == S_ACC);
    assign span   = win_n_reg - lag_reg;
    assign last_i = AW'(span - CW'(1));
    assign lagged = CW'(i_reg) + lag_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= sample;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[i_reg];
            rd_b_reg <= mem[lagged[AW-1:0]];
        end
    end

    // Correlation datapath: scale by n, remove the sum, multiply.
    always_ff @(posedge clk)
    begin
        nx_a_reg  <= $signed({1'b0, win_n_reg}) * rd_a_reg;
        nx_b_reg  <= $signed({1'b0, win_n_reg}) * rd_b_reg;
        dev_a_reg <= DEV_W'(nx_a_reg) - DEV_W'(win_sum_reg);
        dev_b_reg <= DEV_W'(nx_b_reg) - DEV_W'(win_sum_reg);
        prod_reg  <= dev_a_reg * dev_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
            p3_reg <= 1'b0;
            p4_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= rd_en;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
        end
    end

    assign drained    = !(p1_reg || p2_reg || p3_reg || p4_reg);
    assign c0_eff     = (lag_reg == '0) ? acc_reg : c0_reg;
    assign norm_start = (state_reg == S_DRAIN) && drained && (c0_eff != '0);

    acpd_norm #(
        .CNT_W (CW)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .acc   (acc_reg),
        .c0    (c0_eff),
        .n_cnt (win_n_reg),
        .span  (span),
        .done  (norm_done),
        .ratio (norm_ratio)
    );

    // Peak test on lag k - 1 once r(k) is known; past the window the neighbor is 0.
    assign tail     = (lag_reg == win_n_reg);
    assign cand     = lag_reg - CW'(1);
    assign r_next_v = tail ? STR_W'(0) : r_new_reg;
    assign r_prev_v = (cand == '0) ? STR_W'(0) : r_prev_reg;
    assign at_max   = (lag_reg != '0) && (CMP_W'(cand) == CMP_W'(lag_hi_reg));
    assign qualify  = (lag_reg != '0)
                   && (CMP_W'(cand) >= CMP_W'(lag_lo_reg))
                   && (CMP_W'(cand) <= CMP_W'(lag_hi_reg))
                   && (r_cur_reg >= thresh_reg)
                   && (r_cur_reg >= r_prev_v)
                   && (r_cur_reg >= r_next_v);

    assign out_load = !out_valid_reg || !out_stall;

    // Sequencer with the window counters and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            // The loading state sets valid itself, so the clear is left to other states.
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            if (p4_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (last)
                        begin
                            win_n_reg   <= n_close;
                            win_sum_reg <= sum_close;
                            count_reg   <= '0;
                            sum_reg     <= '0;
                            lag_reg     <= '0;
                            i_reg       <= '0;
                            acc_reg     <= '0;
                            hit_reg     <= 1'b0;
                            hit_lag_reg <= '0;
                            hit_val_reg <= '0;
                            state_reg   <= S_ACC;
                        end
                        else
                        begin
                            count_reg <= n_close;
                            sum_reg   <= sum_close;
                        end
                    end
                end
                S_ACC:
                begin
                    if (i_reg == last_i)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        i_reg <= i_reg + AW'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (drained)
                    begin
                        if (lag_reg == '0)
                        begin
                            c0_reg <= acc_reg;
                        end
                        if (c0_eff == '0)
                        begin
                            r_new_reg <= '0;
                            state_reg <= S_EVAL;
                        end
                        else
                        begin
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_NORM:
                begin
                    if (norm_done)
                    begin
                        r_new_reg <= norm_ratio;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (qualify)
                    begin
                        hit_reg     <= 1'b1;
                        hit_lag_reg <= PER_W'(cand);
                        hit_val_reg <= r_cur_reg;
                        state_reg   <= S_DONE;
                    end
                    else if (at_max || tail)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        r_prev_reg <= r_cur_reg;
                        r_cur_reg  <= r_new_reg;
                        lag_reg    <= lag_reg + CW'(1);
                        if ((lag_reg + CW'(1)) == win_n_reg)
                        begin
                            state_reg <= S_EVAL;
                        end
                        else
                        begin
                            i_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_ACC;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= hit_reg;
                        period_reg    <= hit_lag_reg;
                        strength_reg  <= hit_val_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign period    = period_reg;
    assign strength  = strength_reg;

`ifndef SYNTHESIS
    // A result without a peak carries zero period and strength.
    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (period == '0 && strength == '0))
        else $error("result without a peak has nonzero fields");

    // The fill count never passes the memory depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SAMPLES))
        else $error("sample count beyond memory depth");

    // The peak test only runs once the product pipeline is empty.
    a_eval_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> drained)
        else $error("peak test with products still in flight");

    // A new result comes only from the result-loading state.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the loading state");

    // Samples are never written while products are read or the normalizer runs.
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC || state_reg == S_NORM) |-> !wr_en)
        else $error("sample written during the search");
`endif

endmodule

// ===== verif/tb_autocorrelation_period_detector.sv =====
// Self-checking testbench for autocorrelation_period_detector.
// Drives sample windows and APB register writes and checks each result against
// an in-bench period predictor. Depends on acpd_pkg and the detector RTL.
`timescale 1ns / 100ps

module tb_autocorrelation_period_detector;
    import acpd_pkg::*;

    localparam int DEPTH = 1024;

    typedef struct {
        logic                    hit;
        logic [PER_W-1:0]        lag;
        logic signed [STR_W-1:0] level;
    } period_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] sample = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic found;
    logic [PER_W-1:0] period;
    logic signed [STR_W-1:0] strength;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    // Predictor copy of the registers and the window being loaded.
    logic [PER_W-1:0]        cur_lag_lo;
    logic [PER_W-1:0]        cur_lag_hi;
    logic signed [STR_W-1:0] cur_thresh;
    longint                  win_store [DEPTH];
    int                      win_count;
    longint                  win_sum;

    period_result_t pending_periods[$];
    int  errors = 0;
    int  windows_sent = 0;
    int  items_sent = 0;
    int  periods_found = 0;
    bit  quiet = 1'b0;

    autocorrelation_period_detector uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .period(period), .strength(strength),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Q2.14 normalized correlation, truncated toward zero and saturated.
    function automatic logic signed [STR_W-1:0] q214_ratio(longint c, longint c0,
                                                          int n, int lag);
        logic [127:0] mag;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        mag = c[63] ? 128'(-c) & 128'hffff_ffff_ffff_ffff : 128'(unsigned'(c));
        num = mag * (128'(n) << FRAC_BITS);
        den = 128'(unsigned'(c0)) * 128'(n - lag);
        q = num / den;
        if (c[63])
            return (q > 128'd32768) ? STR_MIN : STR_W'(-q);
        return (q > 128'd32767) ? STR_MAX : STR_W'(q);
    endfunction

    // Close the window: correlate every lag and search for the first peak.
    function automatic period_result_t detect_period();
        period_result_t r;
        longint dev [DEPTH];
        logic signed [STR_W-1:0] corr [DEPTH];
        longint acc;
        longint c0;
        int n;
        int lim;
        int prv;
        int nxt;
        n = win_count;
        r.hit = 1'b0;
        r.lag = '0;
        r.level = '0;
        c0 = 0;
        for (int i = 0; i < n; i++)
            dev[i] = longint'(n) * win_store[i] - win_sum;
        for (int k = 0; k < n; k++)
        begin
            acc = 0;
            for (int i = 0; i + k < n; i++)
                acc += dev[i] * dev[i + k];
            if (k == 0)
                c0 = acc;
            corr[k] = (c0 == 0) ? STR_W'(0) : q214_ratio(acc, c0, n, k);
        end
        if (n > int'(cur_lag_lo))
        begin
            lim = (int'(cur_lag_hi) + 1 < n) ? int'(cur_lag_hi) + 1 : n;
            for (int k = int'(cur_lag_lo); k < lim; k++)
            begin
                prv = (k > 0) ? int'(corr[k - 1]) : 0;
                nxt = (k + 1 < n) ? int'(corr[k + 1]) : 0;
                if (corr[k] >= cur_thresh && int'(corr[k]) >= prv
                    && int'(corr[k]) >= nxt)
                begin
                    r.hit = 1'b1;
                    r.lag = PER_W'(k);
                    r.level = corr[k];
                    break;
                end
            end
        end
        win_count = 0;
        win_sum = 0;
        return r;
    endfunction

    // Drive one beat; valid stays high until the next beat or the drain.
    task automatic send_sample(input logic signed [15:0] value, input logic is_last);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        last <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (win_count < DEPTH)
        begin
            win_store[win_count] = longint'(value);
            win_sum += longint'(value);
            win_count++;
        end
        if (is_last)
        begin
            pending_periods.push_back(detect_period());
            windows_sent++;
        end
    endtask

    // Wait until every expected result is out and the block has settled.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_periods.size() != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LAG_LO: cur_lag_lo = value[PER_W-1:0];
            REG_LAG_HI: cur_lag_hi = value[PER_W-1:0];
            REG_THRESH: cur_thresh = value[STR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apb_check(input logic [1:0] idx, input logic [15:0] want,
                             input logic [15:0] mask);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata[15:0] & mask) !== want)
        begin
            $display("%0t register %0d: expected %h actual %h", $time, idx, want,
                     prdata[15:0] & mask);
            errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_search(input int lo, input int hi, input int thr);
        apb_write(REG_LAG_LO, 32'(lo));
        apb_write(REG_LAG_HI, 32'(hi));
        apb_write(REG_THRESH, 32'(thr));
    endtask

    // Output side: random stall at the falling edge, compare at the rising edge.
    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 15);

    always @(posedge clk)
    begin
        period_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_periods.size() == 0)
            begin
                $display("%0t unexpected result: found=%b period=%0d strength=%0d",
                         $time, found, period, strength);
                errors++;
            end
            else
            begin
                e = pending_periods.pop_front();
                if (e.hit) periods_found++;
                if (found !== e.hit || period !== e.lag || strength !== e.level)
                begin
                    $display("%0t mismatch: expected found=%b period=%0d strength=%0d",
                             $time, e.hit, e.lag, e.level);
                    $display("%0t           actual   found=%b period=%0d strength=%0d",
                             $time, found, period, strength);
                    errors++;
                end
            end
        end
    end

    // Reset values of the registers, then a default-setting periodic window.
    task automatic test_reset_defaults();
        apb_check(REG_LAG_LO, 16'(RST_LAG_LO), 16'h03ff);
        apb_check(REG_LAG_HI, 16'(RST_LAG_HI), 16'h03ff);
        apb_check(REG_THRESH, 16'(RST_THRESH), 16'hffff);
        for (int i = 0; i < 8; i++)
            send_sample((i % 4 < 2) ? 16'sd32767 : -16'sd32768, i == 7);
        drain();
    endtask

    // Constant windows, single sample, lag zero, empty range and extreme thresholds.
    task automatic test_corner_windows();
        set_search(0, 1023, 0);
        send_sample(16'sd1234, 1'b0);
        send_sample(16'sd1234, 1'b0);
        send_sample(16'sd1234, 1'b1);
        send_sample(-16'sd5, 1'b1);
        drain();
        set_search(5, 3, -32768);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd0, 1'b1);
        drain();
        set_search(1023, 1023, 32767);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b1);
        drain();
        set_search(1, 0, -32768);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b1);
        drain();
    endtask

    // Random search settings per phase; mostly periodic windows with noise.
    task automatic test_random_windows();
        logic signed [15:0] pat [64];
        int len;
        int per;
        int kind;
        int thr;
        int budget;
        budget = items_sent + 557;
        while (items_sent < budget)
        begin
            case ($urandom_range(0, 5))
                0: thr = -32768;
                1: thr = 32767;
                2: thr = 0;
                3: thr = 16384;
                default: thr = $urandom_range(0, 65535) - 32768;
            endcase
            set_search($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 6),
                       $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 40), thr);
            quiet = ($urandom_range(0, 4) == 0);
            for (int w = 0; w < 6 && items_sent < budget; w++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                 : $urandom_range(1, 24);
                per = $urandom_range(2, 12);
                kind = $urandom_range(0, 9);
                foreach (pat[j])
                    pat[j] = 16'($urandom());
                for (int i = 0; i < len; i++)
                    if (kind < 6)
                        send_sample(pat[i % per] + 16'($urandom_range(0, 63)) - 16'sd32,
                                    i == len - 1);
                    else if (kind < 9)
                        send_sample(16'($urandom()), i == len - 1);
                    else
                        send_sample(pat[0], i == len - 1);
            end
            drain();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        cur_lag_lo = RST_LAG_LO;
        cur_lag_hi = RST_LAG_HI;
        cur_thresh = RST_THRESH;
        win_count = 0;
        win_sum = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_corner_windows();
        test_random_windows();
        $display("Sent %0d samples in %0d windows; %0d periods were detected.",
                 items_sent, windows_sent, periods_found);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Timeout with %0d results outstanding.", pending_periods.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
